// ===== hw/rtl/blu4_pkg.sv =====
// ----------------------------------------------------------------------------
// blu4_pkg
// Shared sizes, codes and types of the 4x bilinear upscaler.
// ----------------------------------------------------------------------------
package blu4_pkg;

   localparam int SRC_ROWS   = 24;
   localparam int SRC_COLS   = 32;
   localparam int PIXEL_BITS = 16;

   localparam int FRAME_SIZE = SRC_ROWS * SRC_COLS;
   localparam int ADDR_BITS  = 10;
   localparam int POS_BITS   = 7;
   localparam int KIND_BITS  = 2;

   localparam logic [POS_BITS-1:0] FAST_END = POS_BITS'(4 * (SRC_ROWS - 1));
   localparam logic [POS_BITS-1:0] SLOW_END = POS_BITS'(4 * (SRC_COLS - 1));

   localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REQUEST = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

   // operands of one pass through the interpolation unit
   typedef struct packed {
      logic [PIXEL_BITS-1:0] near_val;
      logic [PIXEL_BITS-1:0] far_val;
      logic [1:0]            frac;
   } lerp_op_type;

endpackage

// ===== hw/rtl/blu4_ram.sv =====
// ----------------------------------------------------------------------------
// blu4_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module blu4_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/blu4_lerp.sv =====
// ----------------------------------------------------------------------------
// blu4_lerp
// Quarter-step linear interpolation built from truncating shifts.
// ----------------------------------------------------------------------------
module blu4_lerp
   import blu4_pkg::*;
(
   input  lerp_op_type           op,
   output logic [PIXEL_BITS-1:0] result
);

   logic [2:0]            near_q;
   logic [2:0]            far_q;
   logic [PIXEL_BITS-1:0] near_w;
   logic [PIXEL_BITS-1:0] far_w;
   logic [PIXEL_BITS:0]   sum;

   function automatic logic [PIXEL_BITS-1:0] weigh(input logic [PIXEL_BITS-1:0] v,
                                                   input logic [2:0] quarters);
      logic [PIXEL_BITS-1:0] w;
      case (quarters)
         3'd1:    w = v >> 2;
         3'd2:    w = v >> 1;
         3'd3:    w = (v >> 1) + (v >> 2);
         3'd4:    w = v;
         default: w = '0;
      endcase
      return w;
   endfunction

   always_comb begin
      far_q  = {1'b0, op.frac};
      near_q = 3'd4 - far_q;
      near_w = weigh(op.near_val, near_q);
      far_w  = weigh(op.far_val, far_q);
      sum    = {1'b0, near_w} + {1'b0, far_w};
      // equal neighbors pass through untouched
      if (op.near_val == op.far_val) begin
         result = op.near_val;
      end else begin
         result = sum[PIXEL_BITS-1:0];
      end
   end

endmodule

// ===== hw/rtl/bilinear_upscale_by_four.sv =====
// ----------------------------------------------------------------------------
// bilinear_upscale_by_four
// Frame store plus sequencer that serves a 4x bilinearly upscaled frame.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one source pixel; a restart beat (tuser 2)
// rewinds the output position. A request beat (tuser 1) inside the frame holds
// req_tready low through four reads through the single-port frame store, three
// passes through the one interpolation unit, and the load of the output
// register, so a new request is taken only after the last one has been loaded
// into the output register. The load cycle stretches for as long as an earlier
// result still waits in the output register. Writes and restarts are still taken
// while a result waits there. Requests past the end of the frame give no beat
// until a restart. The frame store needs no clearing pass after reset; reading a
// pixel that was never written gives an arbitrary value.
module bilinear_upscale_by_four
   import blu4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_addr[9:0], pixel_value[25:10], zero fill
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_value[15:0], out_fast_pos[22:16],
                                    // out_slow_pos[29:23], zero fill
   output logic        rsp_tlast    // frame_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [2:0]            step_ff, step_in;
   logic [POS_BITS-1:0]   fast_pos_ff, fast_pos_in;
   logic [POS_BITS-1:0]   slow_pos_ff, slow_pos_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [PIXEL_BITS-1:0] pix_ff [4];
   logic [PIXEL_BITS-1:0] pix_in [4];
   logic [PIXEL_BITS-1:0] q1_ff, q1_in;
   logic [PIXEL_BITS-1:0] q2_ff, q2_in;
   logic [PIXEL_BITS-1:0] val_ff, val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_BITS-1:0]   rsp_fast_ff, rsp_fast_in;
   logic [POS_BITS-1:0]   rsp_slow_ff, rsp_slow_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [KIND_BITS-1:0]  req_kind;
   logic [ADDR_BITS-1:0]  req_addr;
   logic [PIXEL_BITS-1:0] req_value;
   logic                  req_fire;
   logic                  in_frame;
   logic                  out_load;
   logic                  last_pix;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [PIXEL_BITS-1:0] ram_rd_data;
   lerp_op_type           lerp_op;
   logic [PIXEL_BITS-1:0] lerp_result;

   assign req_kind  = req_tuser;
   assign req_addr  = req_tdata[ADDR_BITS-1:0];
   assign req_value = req_tdata[ADDR_BITS +: PIXEL_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_frame   = (fast_pos_ff < FAST_END) && (slow_pos_ff < SLOW_END);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign last_pix   = (fast_pos_ff == FAST_END - 1'b1) && (slow_pos_ff == SLOW_END - 1'b1);

   // read order: top-left, bottom-left, top-right, bottom-right
   always_comb begin
      case (step_ff[1:0])
         2'd0:    rd_addr = base_ff;
         2'd1:    rd_addr = base_ff + ADDR_BITS'(SRC_COLS);
         2'd2:    rd_addr = base_ff + 1'b1;
         default: rd_addr = base_ff + ADDR_BITS'(SRC_COLS + 1);
      endcase
   end

   assign ram_wr_en = req_fire && (req_kind == KIND_WRITE) && (int'(req_addr) < FRAME_SIZE);
   assign ram_addr  = (state_ff == ST_IDLE) ? req_addr : rd_addr;

   blu4_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (FRAME_SIZE)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (req_value),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (step_ff)
         3'd4: begin
            lerp_op.near_val = pix_ff[0];
            lerp_op.far_val  = pix_ff[1];
            lerp_op.frac     = fast_pos_ff[1:0];
         end
         3'd5: begin
            lerp_op.near_val = pix_ff[2];
            lerp_op.far_val  = pix_ff[3];
            lerp_op.frac     = fast_pos_ff[1:0];
         end
         default: begin
            lerp_op.near_val = q1_ff;
            lerp_op.far_val  = q2_ff;
            lerp_op.frac     = slow_pos_ff[1:0];
         end
      endcase
   end

   blu4_lerp u_lerp (
      .op     (lerp_op),
      .result (lerp_result)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      fast_pos_in  = fast_pos_ff;
      slow_pos_in  = slow_pos_ff;
      base_in      = base_ff;
      pix_in       = pix_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_fast_in  = rsp_fast_ff;
      rsp_slow_in  = rsp_slow_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_RESTART)) begin
               fast_pos_in = '0;
               slow_pos_in = '0;
            end
            if (req_fire && (req_kind == KIND_REQUEST) && in_frame) begin
               base_in  = ADDR_BITS'(int'(fast_pos_ff[POS_BITS-1:2]) * SRC_COLS
                                     + int'(slow_pos_ff[POS_BITS-1:2]));
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // data of the read issued last cycle lands now
            if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
               pix_in[step_ff[1:0] - 2'd1] = ram_rd_data;
            end
            if (step_ff == 3'd4) begin
               q1_in = lerp_result;
            end
            if (step_ff == 3'd5) begin
               q2_in = lerp_result;
            end
            if (step_ff == 3'd6) begin
               val_in   = lerp_result;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = val_ff;
               rsp_fast_in  = fast_pos_ff;
               rsp_slow_in  = slow_pos_ff;
               rsp_last_in  = last_pix;
               if (fast_pos_ff == FAST_END - 1'b1) begin
                  fast_pos_in = '0;
                  slow_pos_in = slow_pos_ff + 1'b1;
               end else begin
                  fast_pos_in = fast_pos_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fast_pos_ff  <= '0;
         slow_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fast_pos_ff  <= fast_pos_in;
         slow_pos_ff  <= slow_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pix_ff       <= pix_in;
      q1_ff        <= q1_in;
      q2_ff        <= q2_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fast_ff  <= rsp_fast_in;
      rsp_slow_ff  <= rsp_slow_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_slow_ff, rsp_fast_ff, rsp_value_ff};

   // a result beat never carries a position outside the upscaled frame
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_fast_ff < FAST_END) && (rsp_slow_ff < SLOW_END))
      else $error("result position outside frame");

   // an in-frame request blocks the input side on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_kind == KIND_REQUEST) && in_frame) |=> !req_tready)
      else $error("input ready while request in progress");

   // loading the last pixel parks the slow position at the frame end
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_pix) |=> (slow_pos_ff == SLOW_END) && (fast_pos_ff == '0))
      else $error("position not at frame end after last pixel");

   // the output register is never overwritten while a beat is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x bilinear upscaler. Source pixels are written,
// then output pixels are requested and compared beat by beat against a local
// model of the frame store and the output position. Directed corner cases run
// first, then random traffic under two idle mixes, then a run of requests
// back to back with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
   import blu4_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int RUN_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic [POS_BITS-1:0]   fast_pos;
      logic [POS_BITS-1:0]   slow_pos;
      logic                  last;
   } upscaled_pixel_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // pixel_addr[9:0], pixel_value[25:10], zero fill
   logic [1:0]  req_tuser  = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // out_value[15:0], out_fast_pos[22:16],
                                   // out_slow_pos[29:23], zero fill
   logic        rsp_tlast;         // frame_last

   // local copy of the frame store and output position
   logic [PIXEL_BITS-1:0] frame_copy [FRAME_SIZE];
   bit                    pixel_written [FRAME_SIZE];
   logic [POS_BITS-1:0]   next_fast = '0;
   logic [POS_BITS-1:0]   next_slow = '0;
   upscaled_pixel_type    pending_pixels [$];

   int send_idle_pct   = 37;
   int recv_idle_pct   = 79;
   int error_count     = 0;
   int pixels_checked  = 0;
   int beats_sent      = 0;
   int cycle_count     = 0;

   bilinear_upscale_by_four i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [PIXEL_BITS-1:0] weigh_quarters(
      input logic [PIXEL_BITS-1:0] v, input int unsigned quarters);
      case (quarters)
         1: return v >> 2;
         2: return v >> 1;
         3: return (v >> 1) + (v >> 2);
         4: return v;
         default: return '0;
      endcase
   endfunction

   function automatic logic [PIXEL_BITS-1:0] blend_quarters(
      input logic [PIXEL_BITS-1:0] x, input logic [PIXEL_BITS-1:0] y,
      input int unsigned k);
      // equal neighbours pass through unchanged
      if (x == y)
         return x;
      return weigh_quarters(x, 4 - k) + weigh_quarters(y, k);
   endfunction

   function automatic int source_base();
      return int'(next_fast >> 2) * SRC_COLS + int'(next_slow >> 2);
   endfunction

   function automatic bit frame_done();
      return (next_slow >= SLOW_END) || (next_fast >= FAST_END);
   endfunction

   function automatic upscaled_pixel_type upscale_next();
      upscaled_pixel_type    px;
      int                    base;
      logic [PIXEL_BITS-1:0] near_col;
      logic [PIXEL_BITS-1:0] far_col;
      base     = source_base();
      near_col = blend_quarters(frame_copy[base], frame_copy[base + SRC_COLS],
                                next_fast[1:0]);
      far_col  = blend_quarters(frame_copy[base + 1], frame_copy[base + 1 + SRC_COLS],
                                next_fast[1:0]);
      px.value    = blend_quarters(near_col, far_col, next_slow[1:0]);
      px.fast_pos = next_fast;
      px.slow_pos = next_slow;
      px.last     = (next_fast == FAST_END - 1) && (next_slow == SLOW_END - 1);
      return px;
   endfunction

   task automatic track_beat(input logic [KIND_BITS-1:0] kind,
                             input logic [ADDR_BITS-1:0] addr,
                             input logic [PIXEL_BITS-1:0] value);
      case (kind)
         KIND_WRITE: begin
            if (addr < FRAME_SIZE)
               frame_copy[addr] = value;
         end
         KIND_RESTART: begin
            next_fast = '0;
            next_slow = '0;
         end
         KIND_REQUEST: begin
            if (!frame_done()) begin
               pending_pixels.push_back(upscale_next());
               if (next_fast == FAST_END - 1) begin
                  next_fast = '0;
                  next_slow = next_slow + 1'b1;
               end else begin
                  next_fast = next_fast + 1'b1;
               end
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------- stimulus

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      // lean on a few fixed levels so equal neighbours turn up often
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 16'h8000;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [KIND_BITS-1:0] kind,
                            input logic [ADDR_BITS-1:0] addr,
                            input logic [PIXEL_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, value, addr};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (kind == KIND_WRITE && addr < FRAME_SIZE)
         pixel_written[addr] = 1'b1;
      track_beat(kind, addr, value);
      beats_sent++;
   endtask

   // fill in whatever the next request reads, then ask for the pixel
   task automatic request_next();
      int base;
      int corner [4];
      if (!frame_done()) begin
         base   = source_base();
         corner = '{base, base + 1, base + SRC_COLS, base + 1 + SRC_COLS};
         foreach (corner[i])
            if (!pixel_written[corner[i]])
               send_item(KIND_WRITE, ADDR_BITS'(corner[i]), random_pixel());
      end
      send_item(KIND_REQUEST, ADDR_BITS'($urandom), PIXEL_BITS'($urandom));
   endtask

   task automatic test_directed_corners();
      // bright and dark pixels on opposite corners of the first source cell
      send_item(KIND_WRITE, '0, '1);
      send_item(KIND_WRITE, ADDR_BITS'(SRC_COLS), '0);
      send_item(KIND_WRITE, ADDR_BITS'(1), '0);
      send_item(KIND_WRITE, ADDR_BITS'(SRC_COLS + 1), '1);
      repeat (4) send_item(KIND_REQUEST, '0, '0);
      // out-of-range writes and the unused kind must change nothing
      send_item(KIND_WRITE, ADDR_BITS'(FRAME_SIZE), 16'h5a5a);
      send_item(KIND_WRITE, '1, 16'ha5a5);
      send_item(KIND_UNUSED, '1, '1);
      send_item(KIND_RESTART, '1, '1);
      send_item(KIND_REQUEST, '1, '1);
      // equal pixels down the first column
      send_item(KIND_WRITE, '0, 16'h8001);
      send_item(KIND_WRITE, ADDR_BITS'(SRC_COLS), 16'h8001);
      send_item(KIND_RESTART, '0, '0);
      repeat (3) send_item(KIND_REQUEST, '0, '0);
   endtask

   task automatic test_random_traffic(input int beats);
      int                   done_beats;
      int                   pick;
      logic [ADDR_BITS-1:0] addr;
      done_beats = 0;
      while (done_beats < beats) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            request_next();
            done_beats++;
         end else if (pick < 93) begin
            addr = ADDR_BITS'($urandom_range(1023));
            send_item(KIND_WRITE, addr, random_pixel());
            if (addr < FRAME_SIZE)
               done_beats++;
         end else if (pick < 95) begin
            send_item(KIND_RESTART, ADDR_BITS'($urandom), PIXEL_BITS'($urandom));
            done_beats++;
         end else begin
            send_item(KIND_UNUSED, ADDR_BITS'($urandom), PIXEL_BITS'($urandom));
         end
      end
   endtask

   task automatic test_back_to_back(input int requests);
      send_item(KIND_RESTART, '0, '0);
      repeat (requests) request_next();
   endtask

   // -------------------------------------------------------------- checking

   task automatic note_error(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      upscaled_pixel_type got;
      upscaled_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[22:16], rsp_tdata[29:23], rsp_tlast};
         if (pending_pixels.size() == 0) begin
            note_error($sformatf("unexpected beat: value %h at (%0d,%0d) last %b",
                                 got.value, got.fast_pos, got.slow_pos, got.last));
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.value !== want.value)
               note_error($sformatf("value at (%0d,%0d): expected %h, got %h",
                                    want.fast_pos, want.slow_pos, want.value, got.value));
            if (got.fast_pos !== want.fast_pos)
               note_error($sformatf("fast position: expected %0d, got %0d",
                                    want.fast_pos, got.fast_pos));
            if (got.slow_pos !== want.slow_pos)
               note_error($sformatf("slow position: expected %0d, got %0d",
                                    want.slow_pos, got.slow_pos));
            if (got.last !== want.last)
               note_error($sformatf("frame_last at (%0d,%0d): expected %b, got %b",
                                    want.fast_pos, want.slow_pos, want.last, got.last));
         end
      end
   end

   // ------------------------------------------------------------ test order

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_traffic(300);
      send_idle_pct = 79;
      recv_idle_pct = 37;
      test_random_traffic(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_back_to_back(150);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d input beats and %0d checked output pixels",
               beats_sent, pixels_checked);
      $display("writes, restarts, unused kinds and requests under three idle mixes");
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/blu4_pkg.sv
hw/rtl/blu4_ram.sv
hw/rtl/blu4_lerp.sv
hw/rtl/bilinear_upscale_by_four.sv
tb/testbench.sv
